// ----- rtl/vpc_pkg.sv -----
// vpc_pkg: shared types, codes and constants of the vending purchase controller
`default_nettype none

package vpc_pkg;

  localparam int unsigned NUM_PRODUCTS = 3;
  localparam logic [6:0] INITIAL_STOCK = 7'd70;

  // event commands
  localparam logic [2:0] CMD_SELECT  = 3'd0;
  localparam logic [2:0] CMD_CONFIRM = 3'd1;
  localparam logic [2:0] CMD_BACK    = 3'd2;
  localparam logic [2:0] CMD_COIN    = 3'd3;
  localparam logic [2:0] CMD_CANCEL  = 3'd4;

  // coin kinds
  localparam logic [1:0] COIN_ONE     = 2'd0;
  localparam logic [1:0] COIN_HALF    = 2'd1;
  localparam logic [1:0] COIN_QUARTER = 2'd2;
  localparam logic [1:0] COIN_BAD     = 2'd3;

  // result status codes
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CONFIRM   = 4'd1;
  localparam logic [3:0] ST_COINS     = 4'd2;
  localparam logic [3:0] ST_BAD_PICK  = 4'd3;
  localparam logic [3:0] ST_SOLD_OUT  = 4'd4;
  localparam logic [3:0] ST_BAD_COIN  = 4'd5;
  localparam logic [3:0] ST_REFUNDED  = 4'd6;
  localparam logic [3:0] ST_VENDED    = 4'd7;
  localparam logic [3:0] ST_PICK_CANC = 4'd8;
  localparam logic [3:0] ST_IGNORED   = 4'd9;

  // purchase phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_PAY     = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_PRICE_FIRST  = 3'd0;
  localparam logic [2:0] REG_PRICE_SECOND = 3'd1;
  localparam logic [2:0] REG_PRICE_THIRD  = 3'd2;
  localparam logic [2:0] REG_MARK_FIRST   = 3'd3;
  localparam logic [2:0] REG_MARK_SECOND  = 3'd4;
  localparam logic [2:0] REG_MARK_THIRD   = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] product_pick;
    logic [1:0] coin_kind;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  chosen_product;
    logic [7:0]  amount_due;
    logic [8:0]  amount_paid;
    logic [8:0]  money_back;
    logic [6:0]  stock_left;
    logic        low_stock;
    logic [31:0] sales_total;
  } out_t;

  typedef struct packed {
    logic [NUM_PRODUCTS-1:0][7:0] price;
    logic [NUM_PRODUCTS-1:0][6:0] mark;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/vending_purchase_controller_unit.sv -----
// vending_purchase_controller_unit: top level with event channel, result channel and apb port
//
// Events (select, confirm, go back, coin, cancel) arrive on the cmd channel and each one
// gives exactly one result item on the res channel. A transfer happens on a rising edge
// with valid high and stall low.
// An event goes into an input register, is then evaluated against the purchase state and
// its result is registered in the output register together with res_valid. One event is
// taken every cycle while res_stall stays low; the purchase state is a handful of small
// registers updated in a single pass, so consecutive events chain without bubbles.
// When res_stall is high the output register holds its result; the input register then
// fills and cmd_stall rises until the result is taken, so nothing is dropped.
// Prices and low-stock marks are written over the apb port (byte address 4*index) and
// read back there; pready is always high.
// Synchronous reset restores the default prices and marks, empties both pipeline
// registers, returns to idle and sets every stock counter to its initial level.
`default_nettype none

module vending_purchase_controller_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire vpc_pkg::in_t  cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output vpc_pkg::out_t      res,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  vpc_pkg::cfg_t cfg;
  vpc_pkg::in_t  item;
  vpc_pkg::out_t result;
  logic          item_valid;
  logic          out_free;
  logic          step;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  assign out_free  = !res_valid || !res_stall;
  assign step      = item_valid && out_free;
  assign cmd_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.price[0] <= 8'd6;
      cfg.price[1] <= 8'd8;
      cfg.price[2] <= 8'd3;
      cfg.mark[0]  <= 7'd2;
      cfg.mark[1]  <= 7'd3;
      cfg.mark[2]  <= 7'd5;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        vpc_pkg::REG_PRICE_FIRST:  cfg.price[0] <= pwdata[7:0];
        vpc_pkg::REG_PRICE_SECOND: cfg.price[1] <= pwdata[7:0];
        vpc_pkg::REG_PRICE_THIRD:  cfg.price[2] <= pwdata[7:0];
        vpc_pkg::REG_MARK_FIRST:   cfg.mark[0]  <= pwdata[6:0];
        vpc_pkg::REG_MARK_SECOND:  cfg.mark[1]  <= pwdata[6:0];
        vpc_pkg::REG_MARK_THIRD:   cfg.mark[2]  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      vpc_pkg::REG_PRICE_FIRST:  prdata = {24'd0, cfg.price[0]};
      vpc_pkg::REG_PRICE_SECOND: prdata = {24'd0, cfg.price[1]};
      vpc_pkg::REG_PRICE_THIRD:  prdata = {24'd0, cfg.price[2]};
      vpc_pkg::REG_MARK_FIRST:   prdata = {25'd0, cfg.mark[0]};
      vpc_pkg::REG_MARK_SECOND:  prdata = {25'd0, cfg.mark[1]};
      vpc_pkg::REG_MARK_THIRD:   prdata = {25'd0, cfg.mark[2]};
      default:                   prdata = 32'd0;
    endcase
  end

  // input register: refills in the same cycle it hands its event on
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      item_valid <= 1'b1;
    end else if (out_free) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) item <= cmd;
  end

  vpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= result;
  end

endmodule

`default_nettype wire

// ----- rtl/vpc_core.sv -----
// vpc_core: purchase state and its combinational event update
`default_nettype none

module vpc_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire vpc_pkg::in_t item,
  input  wire vpc_pkg::cfg_t cfg,
  output vpc_pkg::out_t     result
);

  logic [1:0]       phase, phase_next;
  logic [1:0]       picked, picked_next;
  logic [8:0]       paid, paid_next;
  logic [2:0][6:0]  stock, stock_next;
  logic [31:0]      sales, sales_next;

  logic [7:0]  price_cur;
  logic [2:0]  coin_val;
  logic [8:0]  paid_sum;
  logic [32:0] sales_sum;
  logic [6:0]  stock_dec;
  logic [1:0]  idx;
  logic [1:0]  shown;
  logic [7:0]  price_next;
  logic        done;

  function automatic logic [7:0] price_of(input vpc_pkg::cfg_t c, input logic [1:0] p);
    if (p == 2'd0) return 8'd0;
    return c.price[p - 2'd1];
  endfunction

  function automatic logic [6:0] stock_of(input logic [2:0][6:0] s, input logic [1:0] p);
    if (p == 2'd0) return 7'd0;
    return s[p - 2'd1];
  endfunction

  always_comb begin
    phase_next  = phase;
    picked_next = picked;
    paid_next   = paid;
    stock_next  = stock;
    sales_next  = sales;
    done        = 1'b0;
    shown       = picked;
    idx         = picked - 2'd1;
    stock_dec   = 7'd0;
    result      = '0;
    result.status = vpc_pkg::ST_IGNORED;

    price_cur = price_of(cfg, picked);
    case (item.coin_kind)
      vpc_pkg::COIN_ONE:  coin_val = 3'd4;
      vpc_pkg::COIN_HALF: coin_val = 3'd2;
      default:            coin_val = 3'd1;
    endcase
    paid_sum  = paid + {6'd0, coin_val};
    sales_sum = {1'b0, sales} + {25'd0, price_cur};

    case (item.command)
      vpc_pkg::CMD_SELECT: begin
        if (phase == vpc_pkg::PH_IDLE) begin
          if (item.product_pick == 2'd0) begin
            result.status = vpc_pkg::ST_PICK_CANC;
          end else if (stock_of(stock, item.product_pick) == 7'd0) begin
            result.status = vpc_pkg::ST_SOLD_OUT;
          end else begin
            picked_next   = item.product_pick;
            phase_next    = vpc_pkg::PH_CONFIRM;
            result.status = vpc_pkg::ST_CONFIRM;
          end
          shown = picked_next;
        end
      end
      vpc_pkg::CMD_CONFIRM: begin
        if (phase == vpc_pkg::PH_CONFIRM) begin
          phase_next    = vpc_pkg::PH_PAY;
          paid_next     = 9'd0;
          result.status = vpc_pkg::ST_COINS;
        end
      end
      vpc_pkg::CMD_BACK: begin
        if (phase == vpc_pkg::PH_CONFIRM) begin
          phase_next    = vpc_pkg::PH_IDLE;
          picked_next   = 2'd0;
          shown         = 2'd0;
          result.status = vpc_pkg::ST_IDLE;
        end
      end
      vpc_pkg::CMD_COIN: begin
        if (phase == vpc_pkg::PH_PAY) begin
          if (item.coin_kind == vpc_pkg::COIN_BAD) begin
            result.status = vpc_pkg::ST_BAD_COIN;
          end else if (paid_sum >= {1'b0, price_cur}) begin
            result.status      = vpc_pkg::ST_VENDED;
            result.money_back  = paid_sum - {1'b0, price_cur};
            result.amount_paid = paid_sum;
            if (picked != 2'd0) begin
              stock_dec = stock[idx];
              if (stock_dec != 7'd0) stock_dec = stock_dec - 7'd1;
              stock_next[idx]  = stock_dec;
              result.low_stock = (stock_dec <= cfg.mark[idx]);
            end
            // the running total sticks at all ones
            sales_next  = sales_sum[32] ? 32'hFFFF_FFFF : sales_sum[31:0];
            phase_next  = vpc_pkg::PH_IDLE;
            picked_next = 2'd0;
            paid_next   = 9'd0;
            done        = 1'b1;
          end else begin
            paid_next     = paid_sum;
            result.status = vpc_pkg::ST_COINS;
          end
        end
      end
      vpc_pkg::CMD_CANCEL: begin
        if (phase == vpc_pkg::PH_PAY) begin
          result.status      = vpc_pkg::ST_REFUNDED;
          result.money_back  = paid;
          result.amount_paid = paid;
          phase_next         = vpc_pkg::PH_IDLE;
          picked_next        = 2'd0;
          paid_next          = 9'd0;
          done               = 1'b1;
        end else if (phase == vpc_pkg::PH_CONFIRM) begin
          result.status = vpc_pkg::ST_PICK_CANC;
          phase_next    = vpc_pkg::PH_IDLE;
          picked_next   = 2'd0;
          shown         = 2'd0;
        end
      end
      default: ;
    endcase

    price_next = price_of(cfg, picked_next);
    if (!done) begin
      if (phase_next == vpc_pkg::PH_PAY) begin
        result.amount_paid = paid_next;
        // due is floored at zero when the price has been lowered meanwhile
        if ({1'b0, price_next} > paid_next) begin
          result.amount_due = price_next - paid_next[7:0];
        end
      end else if (phase_next == vpc_pkg::PH_CONFIRM) begin
        result.amount_due = price_next;
      end
    end

    result.chosen_product = shown;
    result.stock_left     = stock_of(stock_next, shown);
    result.sales_total    = sales_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= vpc_pkg::PH_IDLE;
      picked <= 2'd0;
      paid   <= 9'd0;
      stock  <= {vpc_pkg::NUM_PRODUCTS{vpc_pkg::INITIAL_STOCK}};
      sales  <= 32'd0;
    end else if (step) begin
      phase  <= phase_next;
      picked <= picked_next;
      paid   <= paid_next;
      stock  <= stock_next;
      sales  <= sales_next;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_vending_purchase_controller_unit.sv -----
// tb_vending_purchase_controller_unit: self-checking testbench, directed event table then random purchases
module tb_vending_purchase_controller_unit;

  localparam int LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BATCH = 50;

  // command codes with no meaning to the block, and register slots past the last one
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_stall;
  vpc_pkg::in_t  cmd;
  logic          res_valid;
  logic          res_stall;
  vpc_pkg::out_t res;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [4:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  vending_purchase_controller_unit u_top (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  typedef struct {
    vpc_pkg::in_t  ev;
    bit            typed;
    vpc_pkg::out_t want;
  } script_row_t;

  // shadow of the purchase state and the price/mark registers
  logic [1:0]  m_phase;
  logic [1:0]  m_picked;
  logic [8:0]  m_paid;
  logic [6:0]  m_stock [1:3];
  logic [31:0] m_sales;
  logic [7:0]  m_price [1:3];
  logic [6:0]  m_mark [1:3];

  vpc_pkg::out_t expected_results [$];
  script_row_t   script [$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] price_for(input logic [1:0] p);
    price_for = (p == 2'd0) ? 8'd0 : m_price[p];
  endfunction

  function automatic logic [6:0] stock_for(input logic [1:0] p);
    stock_for = (p == 2'd0) ? 7'd0 : m_stock[p];
  endfunction

  function automatic vpc_pkg::out_t result_of(input logic [3:0] st, input int prod,
                                              input int due, input int paid,
                                              input int back, input int left,
                                              input int low, input int total);
    vpc_pkg::out_t r;
    r.status = st;
    r.chosen_product = 2'(prod);
    r.amount_due = 8'(due);
    r.amount_paid = 9'(paid);
    r.money_back = 9'(back);
    r.stock_left = 7'(left);
    r.low_stock = 1'(low);
    r.sales_total = 32'(total);
    return r;
  endfunction

  // applies one event to the shadow state and returns the result it should give
  function automatic vpc_pkg::out_t purchase_result(input vpc_pkg::in_t ev);
    vpc_pkg::out_t r;
    logic [7:0]    price;
    logic [8:0]    coin_value;
    logic [32:0]   total;
    logic          closed;
    r = '0;
    r.status = vpc_pkg::ST_IGNORED;
    r.chosen_product = m_picked;
    closed = 1'b0;
    price = price_for(m_picked);
    case (ev.coin_kind)
      vpc_pkg::COIN_ONE:  coin_value = 9'd4;
      vpc_pkg::COIN_HALF: coin_value = 9'd2;
      default:            coin_value = 9'd1;
    endcase
    if (ev.command == vpc_pkg::CMD_SELECT && m_phase == vpc_pkg::PH_IDLE) begin
      if (ev.product_pick == 2'd0) begin
        r.status = vpc_pkg::ST_PICK_CANC;
      end else if (stock_for(ev.product_pick) == 7'd0) begin
        r.status = vpc_pkg::ST_SOLD_OUT;
      end else begin
        m_picked = ev.product_pick;
        m_phase = vpc_pkg::PH_CONFIRM;
        r.status = vpc_pkg::ST_CONFIRM;
      end
      r.chosen_product = m_picked;
    end else if (ev.command == vpc_pkg::CMD_CONFIRM && m_phase == vpc_pkg::PH_CONFIRM) begin
      m_phase = vpc_pkg::PH_PAY;
      m_paid = 9'd0;
      r.status = vpc_pkg::ST_COINS;
    end else if (ev.command == vpc_pkg::CMD_BACK && m_phase == vpc_pkg::PH_CONFIRM) begin
      m_phase = vpc_pkg::PH_IDLE;
      m_picked = 2'd0;
      r.chosen_product = 2'd0;
      r.status = vpc_pkg::ST_IDLE;
    end else if (ev.command == vpc_pkg::CMD_COIN && m_phase == vpc_pkg::PH_PAY) begin
      if (ev.coin_kind == vpc_pkg::COIN_BAD) begin
        r.status = vpc_pkg::ST_BAD_COIN;
      end else begin
        m_paid = m_paid + coin_value;
        if (m_paid >= {1'b0, price}) begin
          r.status = vpc_pkg::ST_VENDED;
          r.money_back = m_paid - {1'b0, price};
          r.amount_paid = m_paid;
          if (m_stock[m_picked] != 7'd0) m_stock[m_picked] = m_stock[m_picked] - 7'd1;
          r.low_stock = (m_stock[m_picked] <= m_mark[m_picked]);
          total = {1'b0, m_sales} + {25'd0, price};
          m_sales = total[32] ? 32'hFFFF_FFFF : total[31:0];
          r.chosen_product = m_picked;
          m_phase = vpc_pkg::PH_IDLE;
          m_picked = 2'd0;
          m_paid = 9'd0;
          closed = 1'b1;
        end else begin
          r.status = vpc_pkg::ST_COINS;
        end
      end
    end else if (ev.command == vpc_pkg::CMD_CANCEL && m_phase == vpc_pkg::PH_PAY) begin
      r.status = vpc_pkg::ST_REFUNDED;
      r.money_back = m_paid;
      r.amount_paid = m_paid;
      r.chosen_product = m_picked;
      m_phase = vpc_pkg::PH_IDLE;
      m_picked = 2'd0;
      m_paid = 9'd0;
      closed = 1'b1;
    end else if (ev.command == vpc_pkg::CMD_CANCEL && m_phase == vpc_pkg::PH_CONFIRM) begin
      r.status = vpc_pkg::ST_PICK_CANC;
      m_phase = vpc_pkg::PH_IDLE;
      m_picked = 2'd0;
      r.chosen_product = 2'd0;
    end
    if (!closed) begin
      price = price_for(m_picked);
      r.amount_paid = (m_phase == vpc_pkg::PH_PAY) ? m_paid : 9'd0;
      if (m_phase == vpc_pkg::PH_CONFIRM) r.amount_due = price;
      else if (m_phase == vpc_pkg::PH_PAY && {1'b0, price} > m_paid)
        r.amount_due = price - m_paid[7:0];
    end
    r.stock_left = stock_for(r.chosen_product);
    r.sales_total = m_sales;
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_event(input vpc_pkg::in_t ev, input bit typed, input vpc_pkg::out_t want);
    vpc_pkg::out_t predicted;
    int            gap;
    cmd <= ev;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = purchase_result(ev);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic add_row(input vpc_pkg::in_t ev, input bit typed, input vpc_pkg::out_t want);
    script_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  // wait until every expected result is in and the pipeline is empty
  task automatic settle();
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      vpc_pkg::REG_PRICE_FIRST:  m_price[1] = value[7:0];
      vpc_pkg::REG_PRICE_SECOND: m_price[2] = value[7:0];
      vpc_pkg::REG_PRICE_THIRD:  m_price[3] = value[7:0];
      vpc_pkg::REG_MARK_FIRST:   m_mark[1] = value[6:0];
      vpc_pkg::REG_MARK_SECOND:  m_mark[2] = value[6:0];
      vpc_pkg::REG_MARK_THIRD:   m_mark[3] = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper data bits are random so the register masking gets exercised
  task automatic write_config(input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] p3,
                              input logic [6:0] k1, input logic [6:0] k2, input logic [6:0] k3);
    settle();
    reg_write(vpc_pkg::REG_PRICE_FIRST, {24'($urandom), p1});
    reg_write(vpc_pkg::REG_PRICE_SECOND, {24'($urandom), p2});
    reg_write(vpc_pkg::REG_PRICE_THIRD, {24'($urandom), p3});
    reg_write(vpc_pkg::REG_MARK_FIRST, {25'($urandom), k1});
    reg_write(vpc_pkg::REG_MARK_SECOND, {25'($urandom), k2});
    reg_write(vpc_pkg::REG_MARK_THIRD, {25'($urandom), k3});
  endtask

  // leave a payment open so the next price write lands mid-purchase
  task automatic open_payment();
    while (m_phase != vpc_pkg::PH_PAY)
      send_event({(m_phase == vpc_pkg::PH_IDLE) ? vpc_pkg::CMD_SELECT : vpc_pkg::CMD_CONFIRM,
                  2'd1, vpc_pkg::COIN_ONE}, 1'b0, '0);
  endtask

  // mostly well-formed purchases steered by the shadow phase, some raw noise
  task automatic random_events(input int count);
    vpc_pkg::in_t ev;
    int           roll;
    repeat (count) begin
      ev.product_pick = 2'($urandom);
      ev.coin_kind = 2'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        ev.command = 3'($urandom_range(0, 7));
      end else begin
        case (m_phase)
          vpc_pkg::PH_IDLE: begin
            ev.command = vpc_pkg::CMD_SELECT;
            if (roll >= 20) ev.product_pick = 2'($urandom_range(1, 3));
          end
          vpc_pkg::PH_CONFIRM: begin
            if (roll < 80) ev.command = vpc_pkg::CMD_CONFIRM;
            else if (roll < 90) ev.command = vpc_pkg::CMD_BACK;
            else ev.command = vpc_pkg::CMD_CANCEL;
          end
          default: begin
            if (roll < 16) begin
              ev.command = vpc_pkg::CMD_CANCEL;
            end else begin
              ev.command = vpc_pkg::CMD_COIN;
              if (roll >= 24) ev.coin_kind = 2'($urandom_range(0, 2));
            end
          end
        endcase
      end
      send_event(ev, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  // result side: compare every transfer with the oldest expectation
  always @(posedge clk) begin
    vpc_pkg::out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, res);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("chosen_product", 32'(want.chosen_product), 32'(res.chosen_product));
        check_field("amount_due", 32'(want.amount_due), 32'(res.amount_due));
        check_field("amount_paid", 32'(want.amount_paid), 32'(res.amount_paid));
        check_field("money_back", 32'(want.money_back), 32'(res.money_back));
        check_field("stock_left", 32'(want.stock_left), 32'(res.stock_left));
        check_field("low_stock", 32'(want.low_stock), 32'(res.low_stock));
        check_field("sales_total", want.sales_total, res.sales_total);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("vending_purchase_controller_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
          stall_left = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    vpc_pkg::in_t ev;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    m_phase = vpc_pkg::PH_IDLE;
    m_picked = 2'd0;
    m_paid = 9'd0;
    m_sales = 32'd0;
    m_price[1] = 8'd6;
    m_price[2] = 8'd8;
    m_price[3] = 8'd3;
    m_mark[1] = 7'd2;
    m_mark[2] = 7'd3;
    m_mark[3] = 7'd5;
    for (int p = 1; p <= 3; p++) m_stock[p] = vpc_pkg::INITIAL_STOCK;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wrong-phase events straight after reset
    add_row({vpc_pkg::CMD_CANCEL, 2'd0, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_CONFIRM, 2'd3, vpc_pkg::COIN_BAD}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_COIN, 2'd1, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_BACK, 2'd2, vpc_pkg::COIN_HALF}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({CMD_UNUSED_LO, 2'd1, vpc_pkg::COIN_QUARTER}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({CMD_UNUSED_HI, 2'd3, vpc_pkg::COIN_BAD}, 1'b1,
            result_of(vpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_SELECT, 2'd0, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_PICK_CANC, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_SELECT, 2'd3, vpc_pkg::COIN_QUARTER}, 1'b1,
            result_of(vpc_pkg::ST_CONFIRM, 3, 3, 0, 0, int'(vpc_pkg::INITIAL_STOCK), 0, 0));
    add_row({vpc_pkg::CMD_SELECT, 2'd1, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_COIN, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_BACK, 2'd0, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_IDLE, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_SELECT, 2'd2, vpc_pkg::COIN_BAD}, 1'b0, '0);
    add_row({vpc_pkg::CMD_CANCEL, 2'd0, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_PICK_CANC, 0, 0, 0, 0, 0, 0, 0));
    add_row({vpc_pkg::CMD_SELECT, 2'd1, vpc_pkg::COIN_HALF}, 1'b0, '0);
    add_row({vpc_pkg::CMD_CONFIRM, 2'd0, vpc_pkg::COIN_ONE}, 1'b1,
            result_of(vpc_pkg::ST_COINS, 1, 6, 0, 0, int'(vpc_pkg::INITIAL_STOCK), 0, 0));
    add_row({vpc_pkg::CMD_BACK, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_SELECT, 2'd2, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_COIN, 2'd0, vpc_pkg::COIN_BAD}, 1'b1,
            result_of(vpc_pkg::ST_BAD_COIN, 1, 6, 0, 0, int'(vpc_pkg::INITIAL_STOCK), 0, 0));
    add_row({vpc_pkg::CMD_COIN, 2'd3, vpc_pkg::COIN_QUARTER}, 1'b0, '0);
    add_row({vpc_pkg::CMD_COIN, 2'd0, vpc_pkg::COIN_HALF}, 1'b0, '0);
    add_row({vpc_pkg::CMD_COIN, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);
    // refund of a part payment
    add_row({vpc_pkg::CMD_SELECT, 2'd2, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_CONFIRM, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_COIN, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);
    add_row({vpc_pkg::CMD_CANCEL, 2'd0, vpc_pkg::COIN_ONE}, 1'b0, '0);

    gap_pct = 30;
    stall_pct = 30;
    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

    write_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    random_events(RANDOM_BATCH);

    // top prices and marks, raised while a payment is open
    open_payment();
    write_config(8'd255, 8'd255, 8'd255, 7'd127, 7'd127, 7'd127);
    gap_pct = 10;
    stall_pct = 50;
    random_events(RANDOM_BATCH);

    // lowest prices: the open payment vends on its next valid coin
    open_payment();
    write_config(8'd1, 8'd1, 8'd1, 7'd0, 7'd0, 7'd0);
    gap_pct = 50;
    stall_pct = 10;
    random_events(RANDOM_BATCH);

    // empty product three, then try to select it
    write_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 8'd1,
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 7'd0);
    reg_write(REG_SPARE_LO, $urandom);
    reg_write(REG_SPARE_HI, $urandom);
    gap_pct = 20;
    stall_pct = 20;
    while (m_stock[3] != 7'd0) begin
      case (m_phase)
        vpc_pkg::PH_IDLE:    ev = {vpc_pkg::CMD_SELECT, 2'd3, vpc_pkg::COIN_ONE};
        vpc_pkg::PH_CONFIRM: ev = {vpc_pkg::CMD_CONFIRM, 2'd3, vpc_pkg::COIN_ONE};
        default:             ev = {vpc_pkg::CMD_COIN, 2'd3, 2'($urandom_range(0, 2))};
      endcase
      send_event(ev, 1'b0, '0);
    end
    send_event({vpc_pkg::CMD_SELECT, 2'd3, vpc_pkg::COIN_ONE}, 1'b0, '0);

    // closing stretch with no idling on either side
    write_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    gap_pct = 0;
    stall_pct = 0;
    random_events(RANDOM_BATCH);

    settle();
    if (mismatches == 0) begin
      $display("vending_purchase_controller_unit: match");
    end else begin
      $display("vending_purchase_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
